// ----- hdl/spge_pkg.sv -----
// ----------------------------------------------------------------------------
// spge_pkg
// Shared types and constants of the shortest-path graph engine.
// ----------------------------------------------------------------------------
`default_nettype none

package spge_pkg;

    localparam int VERTICES  = 16;
    localparam int VX_BITS   = 4;
    localparam int EDGE_BITS = 8;
    localparam int WT_BITS   = 16;
    localparam int DIST_BITS = 21;
    localparam int TOT_BITS  = 20;
    localparam int ST_BITS   = 3;
    localparam int OP_BITS   = 3;

    localparam logic [TOT_BITS-1:0] TOTAL_MAX = '1;

    // opcodes
    localparam logic [OP_BITS-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_DEL     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_EDOWN   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_EUP     = 3'd3;
    localparam logic [OP_BITS-1:0] OP_VDOWN   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_VUP     = 3'd5;
    localparam logic [OP_BITS-1:0] OP_PATH    = 3'd6;
    localparam logic [OP_BITS-1:0] OP_REACH   = 3'd7;

    // result status codes
    localparam logic [ST_BITS-1:0] ST_PATH    = 3'd0;
    localparam logic [ST_BITS-1:0] ST_UNREACH = 3'd1;
    localparam logic [ST_BITS-1:0] ST_SRCDOWN = 3'd2;
    localparam logic [ST_BITS-1:0] ST_REACHV  = 3'd3;
    localparam logic [ST_BITS-1:0] ST_NONE    = 3'd4;

    typedef logic [VX_BITS-1:0]   t_vx;
    typedef logic [DIST_BITS-1:0] t_dist;

endpackage

`default_nettype wire

// ----- hdl/shortest_path_graph_engine.sv -----
// ----------------------------------------------------------------------------
// shortest_path_graph_engine
// Directed graph store of 16 vertices with Dijkstra path and reachability.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one per transfer. Edge and vertex
// edits complete in the cycle of the transfer and produce nothing. Path and
// reachable queries produce 1 to 16 results on m_axis; tlast marks the final
// result of a query, tuser carries the status code.
// A query runs a small sequencer: each settled vertex takes a scan over all
// 16 vertices for the next one (minimum distance; the first candidate in
// reachable mode) plus a relax sweep over the edge weight RAM (one read per
// cycle, registered). A path query then walks back along the predecessors and
// sends one result per cycle while m_axis is ready; a reachable query steps
// over all 16 indices, one per cycle unless m_axis stalls on a member.
// s_axis_tready is low while a query runs. One output register holds the
// current result; a stalled receiver simply holds the sequencer in its emit
// phase. A synchronous reset clears all edges and down marks; the engine is
// ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_path_graph_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[2:0], src_vertex[6:3], dst_vertex[10:7], weight[26:11]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // vertex[3:0], total_distance[23:4]
    output logic [23:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RELAX = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_REMIT = 3'd6;
    localparam logic [2:0] S_ONE   = 3'd7;

    localparam int NV = spge_pkg::VERTICES;

    logic [2:0]  r_state;
    logic [255:0] r_epres;
    logic [255:0] r_edown;
    logic [NV-1:0] r_vdown;
    logic [NV-1:0] r_reached;
    logic [NV-1:0] r_settled;
    spge_pkg::t_dist r_dist [NV];
    spge_pkg::t_vx   r_pred [NV];
    spge_pkg::t_vx   r_pbuf [NV];

    logic            r_mode_reach;
    spge_pkg::t_vx   r_src;
    spge_pkg::t_vx   r_dst;
    spge_pkg::t_vx   r_i;
    logic            r_found;
    spge_pkg::t_vx   r_u;
    spge_pkg::t_dist r_best;
    spge_pkg::t_dist r_du;
    logic [4:0]      r_cnt;
    spge_pkg::t_vx   r_cur;
    logic [4:0]      r_n;
    logic [2:0]      r_one_st;
    spge_pkg::t_vx   r_one_vx;

    logic        r_m_valid;
    logic [23:0] r_m_data;
    logic [2:0]  r_m_user;
    logic        r_m_last;

    // command fields
    logic [2:0]            in_op;
    spge_pkg::t_vx         in_src;
    spge_pkg::t_vx         in_dst;
    logic [15:0]           in_wt;
    logic                  in_acc;

    assign in_op  = s_axis_tdata[2:0];
    assign in_src = s_axis_tdata[6:3];
    assign in_dst = s_axis_tdata[10:7];
    assign in_wt  = s_axis_tdata[26:11];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    logic out_free;
    assign out_free = !r_m_valid || m_axis_tready;

    // edge weight store
    logic [7:0]  rd_addr;
    logic [15:0] ram_rd;
    assign rd_addr = {r_u, r_cnt[3:0]};

    spge_ram #(.WIDTH(spge_pkg::WT_BITS), .DEPTH(256)) u_wt_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && (in_op == spge_pkg::OP_ADD)),
        .i_waddr({in_src, in_dst}),
        .i_wdata(in_wt),
        .i_raddr(rd_addr),
        .o_rdata(ram_rd)
    );

    // presence and down mark read alongside the weight
    logic r_ep_q;
    logic r_ed_q;

    always_ff @(posedge i_clk) begin
        r_ep_q <= r_epres[rd_addr];
        r_ed_q <= r_edown[rd_addr];
    end

    // minimum scan, one vertex a cycle; reachable mode takes the first candidate
    logic            scan_cand;
    logic            n_found;
    spge_pkg::t_vx   n_u;
    spge_pkg::t_dist n_best;

    always_comb begin
        scan_cand = r_reached[r_i] && !r_settled[r_i] &&
                    (!r_found || (!r_mode_reach && (r_dist[r_i] < r_best)));
        n_found = r_found || scan_cand;
        n_u     = scan_cand ? r_i : r_u;
        n_best  = scan_cand ? r_dist[r_i] : r_best;
    end

    // relax of the vertex whose weight is on the RAM output
    spge_pkg::t_vx   rv;
    spge_pkg::t_dist nd;
    logic            rlx_ok;
    logic            rlx_upd;

    always_comb begin
        rv      = r_cnt[3:0] - 4'd1;
        nd      = r_du + {5'd0, ram_rd};
        rlx_ok  = (r_cnt != 5'd0) && r_ep_q && !r_ed_q &&
                  !r_vdown[rv] && !r_settled[rv];
        rlx_upd = rlx_ok && (!r_reached[rv] || (nd < r_dist[rv]));
    end

    // reachable list helpers
    logic [NV-1:0]          src_mask;
    logic [NV-1:0]          others;
    logic [NV-1:0]          above_i;
    logic                   rm_member;
    logic                   rm_last;
    spge_pkg::t_vx          e_idx;
    logic [spge_pkg::TOT_BITS-1:0] sat_tot;

    always_comb begin
        src_mask  = NV'(1) << r_src;
        others    = r_reached & ~src_mask;
        above_i   = ~((NV'(2) << r_i) - NV'(1));
        rm_member = others[r_i];
        rm_last   = (others & above_i) == '0;
        e_idx     = r_n[3:0] - 4'd1;
        sat_tot   = r_dist[r_dst][spge_pkg::DIST_BITS-1] ?
                    spge_pkg::TOTAL_MAX : r_dist[r_dst][spge_pkg::TOT_BITS-1:0];
    end

    // output register loads a new result this cycle
    logic load_out;

    always_comb begin
        case (r_state)
            S_EMIT:  load_out = out_free;
            S_REMIT: load_out = out_free && rm_member;
            S_ONE:   load_out = out_free;
            default: load_out = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_epres   <= '0;
            r_edown   <= '0;
            r_vdown   <= '0;
            r_m_valid <= 1'b0;
            r_n       <= '0;
        end else begin
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_src        <= in_src;
                        r_dst        <= in_dst;
                        r_mode_reach <= (in_op == spge_pkg::OP_REACH);
                        case (in_op)
                            spge_pkg::OP_ADD:   r_epres[{in_src, in_dst}] <= 1'b1;
                            spge_pkg::OP_DEL:   r_epres[{in_src, in_dst}] <= 1'b0;
                            spge_pkg::OP_EDOWN: r_edown[{in_src, in_dst}] <= 1'b1;
                            spge_pkg::OP_EUP:   r_edown[{in_src, in_dst}] <= 1'b0;
                            spge_pkg::OP_VDOWN: r_vdown[in_src] <= 1'b1;
                            spge_pkg::OP_VUP:   r_vdown[in_src] <= 1'b0;
                            default: begin
                                if (r_vdown[in_src]) begin
                                    r_one_st <= (in_op == spge_pkg::OP_REACH) ?
                                                spge_pkg::ST_NONE : spge_pkg::ST_SRCDOWN;
                                    r_one_vx <= in_src;
                                    r_state  <= S_ONE;
                                end else begin
                                    r_reached      <= NV'(1) << in_src;
                                    r_settled      <= '0;
                                    r_dist[in_src] <= '0;
                                    r_i            <= '0;
                                    r_found        <= 1'b0;
                                    r_state        <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_found <= n_found;
                    r_u     <= n_u;
                    r_best  <= n_best;
                    r_i     <= r_i + 4'd1;
                    if (r_i == 4'(NV - 1)) begin
                        if (n_found) begin
                            r_settled[n_u] <= 1'b1;
                            r_du           <= n_best;
                            r_cnt          <= '0;
                            r_state        <= S_RELAX;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RELAX: begin
                    // address k issued while k-1 is relaxed
                    if (rlx_upd) begin
                        r_reached[rv] <= 1'b1;
                        r_dist[rv]    <= nd;
                        r_pred[rv]    <= r_u;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(NV)) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_FIN: begin
                    r_i <= '0;
                    r_n <= '0;
                    if (r_mode_reach) begin
                        if (others == '0) begin
                            r_one_st <= spge_pkg::ST_NONE;
                            r_one_vx <= r_src;
                            r_state  <= S_ONE;
                        end else begin
                            r_state <= S_REMIT;
                        end
                    end else if (!r_reached[r_dst]) begin
                        r_one_st <= spge_pkg::ST_UNREACH;
                        r_one_vx <= r_dst;
                        r_state  <= S_ONE;
                    end else begin
                        r_cur   <= r_dst;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_pbuf[r_n[3:0]] <= r_cur;
                    r_n              <= r_n + 5'd1;
                    r_cur            <= r_pred[r_cur];
                    if ((r_cur == r_src) || (r_n == 5'(NV - 1))) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_m_user  <= spge_pkg::ST_PATH;
                        r_m_last  <= (r_n == 5'd1);
                        r_m_data  <= {(r_n == 5'd1) ? sat_tot : 20'd0, r_pbuf[e_idx]};
                        r_n       <= r_n - 5'd1;
                        if (r_n == 5'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_REMIT: begin
                    if (!rm_member || out_free) begin
                        if (rm_member) begin
                            r_m_user  <= spge_pkg::ST_REACHV;
                            r_m_last  <= rm_last;
                            r_m_data  <= {20'd0, r_i};
                        end
                        r_i <= r_i + 4'd1;
                        if (r_i == 4'(NV - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    if (out_free) begin
                        r_m_user  <= r_one_st;
                        r_m_last  <= 1'b1;
                        r_m_data  <= {20'd0, r_one_vx};
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // only the final path result carries a total
    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[23:4] == 20'd0)
        else $error("total on non-final result");

    // edits never stall the command channel
    a_edit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:1] != 2'b11) |=> s_axis_tready)
        else $error("edit command blocked the engine");

    // reachable results carry no total
    a_reach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == spge_pkg::ST_REACHV ||
                          m_axis_tuser == spge_pkg::ST_NONE) |-> m_axis_tdata[23:4] == 20'd0)
        else $error("total on reachable result");

    // path buffer never overfills
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 5'(NV))
        else $error("path length overflow");

endmodule

`default_nettype wire

// ----- hdl/spge_ram.sv -----
// ----------------------------------------------------------------------------
// spge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest-path graph engine: a directed table of
// commands and queries, then random graphs with path and reachable queries,
// all results checked against a behavioural model or a typed expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [2:0]  st;
        logic [3:0]  vx;
        logic [19:0] tot;
        logic        lst;
    } t_res;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  s;
        logic [3:0]  d;
        logic [15:0] w;
        bit          typed;   // expected result typed in below
        t_res        res;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    shortest_path_graph_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // graph copy
    bit          g_edge [256];
    logic [15:0] g_wt   [256];
    bit          g_edn  [256];
    bit          g_vdn  [16];

    t_res expected_results [$];
    int   errors = 0;
    int   cycles = 0;
    bit   calm = 0;       // no-idle stretch

    function automatic bit usable(int u, int v);
        return g_edge[u*16+v] && !g_edn[u*16+v] && !g_vdn[v];
    endfunction

    function automatic t_res mk(logic [2:0] st, logic [3:0] vx, logic [19:0] tot, bit l);
        t_res r;
        r.st = st; r.vx = vx; r.tot = tot; r.lst = l;
        return r;
    endfunction

    function automatic void queue_result(t_res r);
        expected_results = {expected_results, r};
    endfunction

    task automatic predict_command(logic [2:0] op, logic [3:0] s, logic [3:0] d,
                                   logic [15:0] w);
        int e;
        bit          reach  [16];
        bit          done   [16];
        logic [20:0] best_d [16];
        int          pred   [16];
        int          path   [$];
        int          u, cnt, k, cur;
        bit          found;
        logic [20:0] nd;
        e = s*16 + d;
        case (op)
            spge_pkg::OP_ADD:   begin g_edge[e] = 1; g_wt[e] = w; end
            spge_pkg::OP_DEL:   g_edge[e] = 0;
            spge_pkg::OP_EDOWN: g_edn[e] = 1;
            spge_pkg::OP_EUP:   g_edn[e] = 0;
            spge_pkg::OP_VDOWN: g_vdn[s] = 1;
            spge_pkg::OP_VUP:   g_vdn[s] = 0;
            spge_pkg::OP_PATH: begin
                if (g_vdn[s]) begin
                    queue_result(mk(spge_pkg::ST_SRCDOWN, s, '0, 1'b1));
                    return;
                end
                for (int i = 0; i < 16; i++) begin
                    reach[i] = 0; done[i] = 0; best_d[i] = 0; pred[i] = 0;
                end
                reach[s] = 1;
                forever begin
                    found = 0; u = 0;
                    for (int i = 0; i < 16; i++)
                        if (reach[i] && !done[i] && (!found || best_d[i] < best_d[u])) begin
                            u = i; found = 1;
                        end
                    if (!found) break;
                    done[u] = 1;
                    for (int v = 0; v < 16; v++) begin
                        if (done[v] || !usable(u, v)) continue;
                        nd = best_d[u] + g_wt[u*16+v];
                        if (!reach[v] || nd < best_d[v]) begin
                            reach[v] = 1; best_d[v] = nd; pred[v] = u;
                        end
                    end
                end
                if (!reach[d]) begin
                    queue_result(mk(spge_pkg::ST_UNREACH, d, '0, 1'b1));
                    return;
                end
                cur = d;
                forever begin
                    path.push_front(cur);
                    if (cur == s || path.size() >= 16) break;
                    cur = pred[cur];
                end
                for (int i = 0; i < path.size(); i++)
                    if (i == path.size()-1)
                        queue_result(mk(spge_pkg::ST_PATH, 4'(path[i]),
                            best_d[d] > 21'hFFFFF ? 20'hFFFFF : best_d[d][19:0], 1'b1));
                    else
                        queue_result(mk(spge_pkg::ST_PATH, 4'(path[i]), '0, 1'b0));
            end
            default: begin
                if (g_vdn[s]) begin
                    queue_result(mk(spge_pkg::ST_NONE, s, '0, 1'b1));
                    return;
                end
                for (int i = 0; i < 16; i++) reach[i] = 0;
                reach[s] = 1;
                path = {path, int'(s)};
                while (path.size() > 0) begin
                    u = path.pop_back();
                    for (int v = 0; v < 16; v++)
                        if (!reach[v] && usable(u, v) && path.size() < 16) begin
                            reach[v] = 1; path = {path, v};
                        end
                end
                cnt = 0;
                for (int i = 0; i < 16; i++) if (i != s && reach[i]) cnt++;
                if (cnt == 0) begin
                    queue_result(mk(spge_pkg::ST_NONE, s, '0, 1'b1));
                    return;
                end
                k = 0;
                for (int i = 0; i < 16; i++)
                    if (i != s && reach[i]) begin
                        k++;
                        queue_result(mk(spge_pkg::ST_REACHV, 4'(i), '0, k == cnt));
                    end
            end
        endcase
    endtask

    task automatic send(logic [2:0] op, logic [3:0] s, logic [3:0] d, logic [15:0] w);
        while (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {5'd0, w, d, s, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_res got, exp_r;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            got = mk(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[23:4], m_axis_tlast);
            if (expected_results.size() == 0) begin
                $error("unexpected result st=%0d vx=%0d", got.st, got.vx);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.st !== exp_r.st) begin
                    $error("status exp %0d got %0d", exp_r.st, got.st); errors++;
                end
                if (got.vx !== exp_r.vx) begin
                    $error("vertex exp %0d got %0d", exp_r.vx, got.vx); errors++;
                end
                if (got.tot !== exp_r.tot) begin
                    $error("total_distance exp %0h got %0h", exp_r.tot, got.tot); errors++;
                end
                if (got.lst !== exp_r.lst) begin
                    $error("last exp %0d got %0d", exp_r.lst, got.lst); errors++;
                end
            end
        end
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
        if (cycles > 2000000) begin
            $display("FAIL");
            $finish;
        end
    end

    t_row dir [$];

    task automatic row(logic [2:0] op, logic [3:0] s, logic [3:0] d, logic [15:0] w,
                       bit typed = 0, t_res r = '0);
        t_row t;
        t.op = op; t.s = s; t.d = d; t.w = w; t.typed = typed; t.res = r;
        dir = {dir, t};
    endtask

    initial begin
        logic [2:0] op;
        logic [3:0] a, b;
        int n;
        for (int i = 0; i < 256; i++) begin g_edge[i] = 0; g_wt[i] = 0; g_edn[i] = 0; end
        for (int i = 0; i < 16; i++) g_vdn[i] = 0;

        // directed table
        row(spge_pkg::OP_REACH, 0, 0, 0, 1, mk(spge_pkg::ST_NONE, 0, 0, 1));
        row(spge_pkg::OP_PATH, 0, 15, 0, 1, mk(spge_pkg::ST_UNREACH, 15, 0, 1));
        row(spge_pkg::OP_PATH, 5, 5, 0, 1, mk(spge_pkg::ST_PATH, 5, 0, 1));
        row(spge_pkg::OP_ADD, 0, 15, 16'hFFFF);
        row(spge_pkg::OP_PATH, 0, 15, 0);
        row(spge_pkg::OP_ADD, 15, 0, 16'h0000);
        row(spge_pkg::OP_ADD, 0, 15, 16'h0100);          // update replaces weight
        row(spge_pkg::OP_ADD, 0, 1, 16'h0080);
        row(spge_pkg::OP_ADD, 1, 15, 16'h0080);          // tie with direct edge
        row(spge_pkg::OP_PATH, 0, 15, 0);
        row(spge_pkg::OP_REACH, 0, 0, 0);
        row(spge_pkg::OP_EDOWN, 0, 15, 0);
        row(spge_pkg::OP_PATH, 0, 15, 0);
        row(spge_pkg::OP_EDOWN, 3, 4, 0);                // mark on absent edge
        row(spge_pkg::OP_DEL, 0, 15, 0);
        row(spge_pkg::OP_ADD, 0, 15, 16'h0001);          // down mark survives re-add
        row(spge_pkg::OP_PATH, 0, 15, 0);
        row(spge_pkg::OP_EUP, 0, 15, 0);
        row(spge_pkg::OP_VDOWN, 0, 0, 0);
        row(spge_pkg::OP_PATH, 0, 15, 0, 1, mk(spge_pkg::ST_SRCDOWN, 0, 0, 1));
        row(spge_pkg::OP_REACH, 0, 0, 0, 1, mk(spge_pkg::ST_NONE, 0, 0, 1));
        row(spge_pkg::OP_VUP, 0, 0, 0);
        row(spge_pkg::OP_VDOWN, 15, 0, 0);
        row(spge_pkg::OP_PATH, 0, 15, 0);                // down destination
        row(spge_pkg::OP_VUP, 15, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir[i]) begin
            if (dir[i].typed) begin
                predict_command(dir[i].op, dir[i].s, dir[i].d, dir[i].w);
                void'(expected_results.pop_back());
                queue_result(dir[i].res);
            end else
                predict_command(dir[i].op, dir[i].s, dir[i].d, dir[i].w);
            send(dir[i].op, dir[i].s, dir[i].d, dir[i].w);
        end

        // random: edge building with frequent queries, a quarter of weights full-range
        n = 0;
        while (n < 200) begin
            calm = (n >= 80 && n < 110);
            case ($urandom_range(9))
                0, 1, 2, 3: op = spge_pkg::OP_ADD;
                4: op = 3'($urandom_range(spge_pkg::OP_DEL, spge_pkg::OP_VUP));
                5, 6, 7: op = spge_pkg::OP_PATH;
                default: op = spge_pkg::OP_REACH;
            endcase
            a = 4'($urandom_range(15));
            b = 4'($urandom_range(15));
            if (op == spge_pkg::OP_ADD) begin
                logic [15:0] w;
                w = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1023));
                predict_command(op, a, b, w);
                send(op, a, b, w);
            end else begin
                logic [15:0] w;
                w = 16'($urandom);
                predict_command(op, a, b, w);
                send(op, a, b, w);
            end
            n++;
        end
        s_axis_tvalid <= 0;
        calm = 0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
